@@ rtl/core/ttsr_pkg.sv @@
// shared types, constants and tables for the tape transport speed ramp
package ttsr_pkg;

	localparam int SPEED_W   = 22;
	localparam int CLOCK_W   = 24;
	localparam int ELAPSED_W = 48;
	localparam int ADJ_W     = 17;
	localparam int FRAC_W    = 32;
	localparam int STEP_BITS = 22;
	localparam int FRAC_TAB_W = 13;

	localparam logic [CLOCK_W-1:0] CLOCK_RESET   = 24'd3579545;
	localparam logic [CLOCK_W-1:0] SCALE_DIVISOR = 24'd25;
	localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 22'sd1310720;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_LOAD,
		CMD_EJECT,
		CMD_PLAY,
		CMD_RECORD,
		CMD_STOP,
		CMD_REWIND,
		CMD_SPEED
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_STEP,
		ST_RAMP,
		ST_MUL,
		ST_SCALE_GO,
		ST_DIV_SCALE,
		ST_FIX,
		ST_TOTAL,
		ST_ACCUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic tick_go;
		logic sat;
		logic div_done;
		logic out_free;
	} fsm_in_t;

	typedef struct packed {
		logic in_ready;
		logic check;
		logic ramp;
		logic mul;
		logic scale;
		logic fix;
		logic total;
		logic accum;
		logic load_out;
		logic div_start;
		logic div_scale;
	} ctrl_t;

	// floor(r * 8192 / 25) for a remainder r below 25
	function automatic logic [FRAC_TAB_W-1:0] frac_tab(input logic [4:0] r);
		logic [FRAC_TAB_W-1:0] v;
		unique case (r)
			5'd0:  v = 13'd0;
			5'd1:  v = 13'd327;
			5'd2:  v = 13'd655;
			5'd3:  v = 13'd983;
			5'd4:  v = 13'd1310;
			5'd5:  v = 13'd1638;
			5'd6:  v = 13'd1966;
			5'd7:  v = 13'd2293;
			5'd8:  v = 13'd2621;
			5'd9:  v = 13'd2949;
			5'd10: v = 13'd3276;
			5'd11: v = 13'd3604;
			5'd12: v = 13'd3932;
			5'd13: v = 13'd4259;
			5'd14: v = 13'd4587;
			5'd15: v = 13'd4915;
			5'd16: v = 13'd5242;
			5'd17: v = 13'd5570;
			5'd18: v = 13'd5898;
			5'd19: v = 13'd6225;
			5'd20: v = 13'd6553;
			5'd21: v = 13'd6881;
			5'd22: v = 13'd7208;
			5'd23: v = 13'd7536;
			5'd24: v = 13'd7864;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/ttsr_div.sv @@
// shared restoring divider, two quotient bits per cycle
module ttsr_div import ttsr_pkg::*; #(
	parameter int DW = 38
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [CLOCK_W-1:0]           rem_init,
	input  logic [DW-1:0]                quo_init,
	input  logic [CLOCK_W-1:0]           divisor,
	input  logic [$clog2(DW/2+1)-1:0]    steps,
	output logic                         done,
	output logic [DW-1:0]                quo,
	output logic [CLOCK_W-1:0]           rem
);

	localparam int CNT_W = $clog2(DW/2 + 1);

	logic [CLOCK_W-1:0] rem_q;
	logic [CLOCK_W-1:0] div_q;
	logic [DW-1:0]      quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [CLOCK_W:0]   t1;
	logic [CLOCK_W:0]   t2;
	logic               ge1;
	logic               ge2;
	logic [CLOCK_W-1:0] r1;
	logic [CLOCK_W-1:0] r2;

	always_comb begin
		t1  = {rem_q, quo_q[DW-1]};
		ge1 = t1 >= {1'b0, div_q};
		r1  = ge1 ? CLOCK_W'(t1 - {1'b0, div_q}) : t1[CLOCK_W-1:0];
		t2  = {r1, quo_q[DW-2]};
		ge2 = t2 >= {1'b0, div_q};
		r2  = ge2 ? CLOCK_W'(t2 - {1'b0, div_q}) : t2[CLOCK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[DW-3:0], ge1, ge2};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/core/ttsr_fsm.sv @@
// sequencer for one transport command
module ttsr_fsm import ttsr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  fsm_in_t ev,
	output ctrl_t   ctrl
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ev.accept) begin
					state_d = ev.tick_go ? ST_CHECK : ST_DONE;
				end
			end
			ST_CHECK:     state_d = ev.sat ? ST_RAMP : ST_DIV_STEP;
			ST_DIV_STEP:  state_d = ev.div_done ? ST_RAMP : ST_DIV_STEP;
			ST_RAMP:      state_d = ST_MUL;
			ST_MUL:       state_d = ST_SCALE_GO;
			ST_SCALE_GO:  state_d = ST_DIV_SCALE;
			ST_DIV_SCALE: state_d = ev.div_done ? ST_FIX : ST_DIV_SCALE;
			ST_FIX:       state_d = ST_TOTAL;
			ST_TOTAL:     state_d = ST_ACCUM;
			ST_ACCUM:     state_d = ST_DONE;
			ST_DONE:      state_d = ev.out_free ? ST_IDLE : ST_DONE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.in_ready  = state_q == ST_IDLE;
		ctrl.check     = state_q == ST_CHECK;
		ctrl.ramp      = state_q == ST_RAMP;
		ctrl.mul       = state_q == ST_MUL;
		ctrl.scale     = state_q == ST_SCALE_GO;
		ctrl.fix       = state_q == ST_FIX;
		ctrl.total     = state_q == ST_TOTAL;
		ctrl.accum     = state_q == ST_ACCUM;
		ctrl.load_out  = (state_q == ST_DONE) && ev.out_free;
		ctrl.div_start = ((state_q == ST_CHECK) && !ev.sat) || (state_q == ST_SCALE_GO);
		ctrl.div_scale = state_q == ST_SCALE_GO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/tape_transport_speed_ramp.sv @@
// top level of the speed-ramped cassette transport
// every command but a running tick goes from its input beat straight to the done state;
// a running tick goes through check, step division (skipped if the ramp step saturates),
// ramp, multiply, scale division, fix, total and accumulate before reaching done
// one command at a time; the next beat is taken once the previous result sits in the output
// register; arst_n clears flags, counts and speeds and loads master_clock_hz with 3579545
module tape_transport_speed_ramp import ttsr_pkg::*; #(
	parameter int CYCLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cycles[15:0], motor_on[16], speed_request[38:17]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // adjusted_cycles[16:0], elapsed_cycles[64:17],
	                               // is_loaded[65], is_running[66], is_recording[67],
	                               // audio_level[69:68], effective_speed[91:70]
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata
);

	localparam int PW    = CYCLE_BITS + 22;
	localparam int DW    = PW + (PW % 2);
	localparam int TW    = DW + 15;
	localparam int CNT_W = $clog2(DW/2 + 1);
	localparam int AW    = CYCLE_BITS + 1;

	// state
	logic [CLOCK_W-1:0]          clk_q;
	logic                        loaded_q;
	logic                        running_q;
	logic                        recording_q;
	logic [ELAPSED_W-1:0]        elapsed_q;
	logic [FRAC_W-1:0]           frac_q;
	logic signed [SPEED_W-1:0]   cur_q;
	logic signed [SPEED_W-1:0]   tgt_q;

	// work registers
	logic [CYCLE_BITS-1:0]       cyc_q;
	logic                        motor_q;
	logic                        sat_q;
	logic signed [SPEED_W:0]     sum_q;
	logic signed [PW:0]          prod_q;
	logic                        neg_q;
	logic [DW+13:0]              addend_q;
	logic [AW-1:0]               adj_q;
	logic                        m_tvalid_q;
	logic [95:0]                 m_tdata_q;

	fsm_in_t ev;
	ctrl_t   ctrl;

	logic                        accept;
	cmd_t                        cmd_in;
	logic                        motor_in;
	logic signed [SPEED_W-1:0]   req_in;
	logic signed [SPEED_W-1:0]   req_clamped;
	logic [CYCLE_BITS-1:0]       cyc_in;
	logic [CLOCK_W-1:0]          clk_eff;
	logic [CYCLE_BITS+2:0]       cyc5;
	logic [CYCLE_BITS-1:0]       cyc5_hi;
	logic                        sat;

	logic                        div_done;
	logic [DW-1:0]               div_quo;
	logic [CLOCK_W-1:0]          div_rem;
	logic [CLOCK_W-1:0]          div_rem_init;
	logic [DW-1:0]               div_quo_init;
	logic [CLOCK_W-1:0]          div_divisor;
	logic [CNT_W-1:0]            div_steps;

	logic [STEP_BITS-1:0]        step;
	logic signed [SPEED_W+1:0]   cur_w;
	logic signed [SPEED_W+1:0]   tgt_w;
	logic signed [SPEED_W+1:0]   up_w;
	logic signed [SPEED_W+1:0]   dn_w;
	logic signed [SPEED_W-1:0]   cur_next;
	logic signed [SPEED_W:0]     sum_next;

	logic signed [CYCLE_BITS+23:0] prod_full;
	logic [PW:0]                 mag;

	logic [4:0]                  rem5;
	logic [4:0]                  rsel;
	logic [DW:0]                 q_ext;
	logic [DW:0]                 a_val;

	logic signed [TW-1:0]        total;
	logic [AW-1:0]               adj_next;
	logic [FRAC_W-1:0]           frac_next;
	logic [ELAPSED_W:0]          elapsed_sum;

	// input decode
	always_comb begin
		cmd_in   = cmd_t'(s_tuser);
		motor_in = s_tdata[16];
		req_in   = $signed(s_tdata[38:17]);
		cyc_in   = CYCLE_BITS'({24'd0, s_tdata[15:0]});
		accept   = s_tvalid && ctrl.in_ready;
		if (req_in > SPEED_LIMIT) begin
			req_clamped = SPEED_LIMIT;
		end else if (req_in < -SPEED_LIMIT) begin
			req_clamped = -SPEED_LIMIT;
		end else begin
			req_clamped = req_in;
		end
	end

	// ramp step bound: floor(cycles * 5 * 2^19 / clock)
	always_comb begin
		clk_eff = (clk_q == '0) ? CLOCK_W'(1) : clk_q;
		cyc5    = (CYCLE_BITS+3)'({cyc_q, 2'b00}) + (CYCLE_BITS+3)'(cyc_q);
		cyc5_hi = cyc5[CYCLE_BITS+2:3];
		sat     = CLOCK_W'(cyc5_hi) >= clk_eff;
	end

	always_comb begin
		mag = prod_q[PW] ? (PW+1)'(0) - prod_q : prod_q;
		if (ctrl.div_scale) begin
			div_rem_init = '0;
			div_quo_init = DW'(mag[PW-1:0]);
			div_divisor  = SCALE_DIVISOR;
			div_steps    = CNT_W'(DW/2);
		end else begin
			div_rem_init = CLOCK_W'(cyc5_hi);
			div_quo_init = {cyc5[2:0], {(DW-3){1'b0}}};
			div_divisor  = clk_eff;
			div_steps    = CNT_W'(STEP_BITS/2);
		end
	end

	// speed ramp toward the target, never past it
	always_comb begin
		step  = sat_q ? '1 : div_quo[STEP_BITS-1:0];
		cur_w = {{2{cur_q[SPEED_W-1]}}, cur_q};
		tgt_w = {{2{tgt_q[SPEED_W-1]}}, tgt_q};
		up_w  = cur_w + $signed({2'b00, step});
		dn_w  = cur_w - $signed({2'b00, step});
		priority if (cur_q < tgt_q) begin
			cur_next = (up_w > tgt_w) ? tgt_q : up_w[SPEED_W-1:0];
		end else if (cur_q > tgt_q) begin
			cur_next = (dn_w < tgt_w) ? tgt_q : dn_w[SPEED_W-1:0];
		end else begin
			cur_next = cur_q;
		end
		sum_next = {cur_q[SPEED_W-1], cur_q} + {cur_next[SPEED_W-1], cur_next};
	end

	assign prod_full = $signed({1'b0, cyc_q}) * sum_q;

	// floor division by 25 rebuilt from the magnitude quotient and remainder
	always_comb begin
		rem5  = div_rem[4:0];
		q_ext = {1'b0, div_quo};
		if (!neg_q) begin
			a_val = q_ext;
			rsel  = rem5;
		end else if (rem5 == 5'd0) begin
			a_val = (DW+1)'(0) - q_ext;
			rsel  = rem5;
		end else begin
			a_val = ~q_ext;
			rsel  = 5'd25 - rem5;
		end
	end

	always_comb begin
		total = $signed({{(TW-CYCLE_BITS-32){1'b0}}, cyc_q, frac_q})
		      + $signed({addend_q[DW+13], addend_q});
		if (total[TW-1]) begin
			adj_next  = '0;
			frac_next = '0;
		end else begin
			adj_next  = total[CYCLE_BITS+32:32];
			frac_next = total[31:0];
		end
		elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(adj_q);
	end

	always_comb begin
		ev.accept   = accept;
		ev.tick_go  = (cmd_in == CMD_TICK) && running_q && motor_in;
		ev.sat      = sat;
		ev.div_done = div_done;
		ev.out_free = !m_tvalid_q || m_tready;
	end

	ttsr_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev),
		.ctrl   (ctrl)
	);

	ttsr_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.rem_init (div_rem_init),
		.quo_init (div_quo_init),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q       <= CLOCK_RESET;
			loaded_q    <= 1'b0;
			running_q   <= 1'b0;
			recording_q <= 1'b0;
			elapsed_q   <= '0;
			frac_q      <= '0;
			cur_q       <= '0;
			tgt_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				clk_q <= cfg_wdata;
			end
			if (accept) begin
				unique case (cmd_in)
					CMD_TICK: begin
					end
					CMD_LOAD: begin
						loaded_q <= 1'b1;
					end
					CMD_EJECT: begin
						loaded_q    <= 1'b0;
						running_q   <= 1'b0;
						recording_q <= 1'b0;
						elapsed_q   <= '0;
						frac_q      <= '0;
					end
					CMD_PLAY: begin
						if (loaded_q) begin
							running_q <= 1'b1;
							elapsed_q <= '0;
							frac_q    <= '0;
						end
					end
					CMD_RECORD: begin
						if (loaded_q) begin
							running_q   <= 1'b1;
							recording_q <= 1'b1;
							elapsed_q   <= '0;
							frac_q      <= '0;
						end
					end
					CMD_STOP: begin
						running_q   <= 1'b0;
						recording_q <= 1'b0;
					end
					CMD_REWIND: begin
						elapsed_q <= '0;
						frac_q    <= '0;
					end
					CMD_SPEED: begin
						tgt_q <= req_clamped;
					end
					default: begin
					end
				endcase
			end
			if (ctrl.ramp) begin
				cur_q <= cur_next;
			end
			if (ctrl.total) begin
				frac_q <= frac_next;
			end
			if (ctrl.accum) begin
				elapsed_q <= elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
			end
			if (ctrl.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cyc_q   <= cyc_in;
			motor_q <= motor_in;
			adj_q   <= '0;
		end
		if (ctrl.check) begin
			sat_q <= sat;
		end
		if (ctrl.ramp) begin
			sum_q <= sum_next;
		end
		if (ctrl.mul) begin
			prod_q <= prod_full[PW:0];
		end
		if (ctrl.scale) begin
			neg_q <= prod_q[PW];
		end
		if (ctrl.fix) begin
			addend_q <= {a_val, frac_tab(rsel)};
		end
		if (ctrl.total) begin
			adj_q <= adj_next;
		end
		if (ctrl.load_out) begin
			m_tdata_q <= {4'd0, cur_q, 1'b0, running_q & motor_q, recording_q, running_q,
			              loaded_q, elapsed_q, ADJ_W'({{16{1'b0}}, adj_q})};
		end
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q <= SPEED_LIMIT) && (cur_q >= -SPEED_LIMIT))
		else $error("effective speed out of range");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tgt_q <= SPEED_LIMIT) && (tgt_q >= -SPEED_LIMIT))
		else $error("target speed out of range");

	a_rec_running: assert property (@(posedge clk) disable iff (!arst_n)
		recording_q |-> running_q)
		else $error("recording without running");

	a_running_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> loaded_q)
		else $error("running without tape");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |=> m_tvalid)
		else $error("finished result not presented");

endmodule
